[rtl/bla_pkg.sv]
// Package for the battery level alarm monitor: field widths, codes,
// register indexes, reset values, conversion constants and the result type.
// No dependencies; used by the channel interfaces and the top level.
package bla_pkg;

  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int LEVEL_W    = 8;
  localparam int PERIOD_W   = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INFORM = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_OK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_PER   = 2'd3;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]  LOW_LIMIT_RST   = 8'd2;
  localparam logic [LEVEL_W-1:0]  HIGH_LIMIT_RST  = 8'd80;
  localparam logic [LEVEL_W-1:0]  CLEAR_LEVEL_RST = 8'd3;
  localparam logic [PERIOD_W-1:0] CHECK_PER_RST   = 18'd180000;

  // Level = (adc * GAIN - OFFSET) >> 16, gain and offset in Q16.
  localparam int GAIN_Q16   = 12896;
  localparam int OFFSET_Q16 = 7340032;
  localparam int FRAC_BITS  = 16;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } res_t;

endpackage

[rtl/bla_if.sv]
// Channel interfaces of the battery level alarm monitor: input items,
// result items and configuration writes, each with valid and ready.
// Depends on bla_pkg.
interface bla_in_if #(
  parameter int ADC_BITS = 10
);
  logic                        valid;
  logic                        ready;
  logic [bla_pkg::CMD_W-1:0]   command;
  logic [ADC_BITS-1:0]         adc_sample;
  logic                        self_started;
  logic                        event_accepted;

  modport source (output valid, command, adc_sample, self_started, event_accepted,
                  input ready);
  modport sink (input valid, command, adc_sample, self_started, event_accepted,
                output ready);
endinterface

interface bla_out_if;
  logic                        valid;
  logic                        ready;
  logic [bla_pkg::KIND_W-1:0]  kind;
  logic [bla_pkg::LEVEL_W-1:0] level;
  logic                        last;

  modport source (output valid, kind, level, last, input ready);
  modport sink (input valid, kind, level, last, output ready);
endinterface

interface bla_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bla_pkg::CFG_IDX_W-1:0]  index;
  logic [bla_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/battery_level_alarm_monitor.sv]
// Battery level alarm monitor, top level. Depends on bla_pkg and bla_if.
// An accepted beat is registered in the input register, processed once the
// result queue has room, and its results are queued and offered from there.
// Throughput: one input beat per cycle while the queue has room; a tick that
// yields two results needs two output beats, and a beat waits in the input
// register while three or more of the four result queue entries are taken.
// Reset (rst_n, synchronous, active low) clears all state and loads the
// register defaults; the block is ready on the first cycle after reset.
module battery_level_alarm_monitor #(
  parameter int ADC_BITS   = 10,
  parameter int TIMER_BITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  bla_in_if.sink     in_ch,
  bla_out_if.source  out_ch,
  bla_cfg_if.sink    cfg_ch
);

  localparam int LW     = bla_pkg::LEVEL_W;
  localparam int PROD_W = ADC_BITS + 15;
  localparam int SH_W   = PROD_W - bla_pkg::FRAC_BITS;
  localparam int CMP_W  = (TIMER_BITS > bla_pkg::PERIOD_W) ? TIMER_BITS : bla_pkg::PERIOD_W;
  localparam int QD     = 4;
  localparam int QA_W   = 2;
  localparam int QC_W   = 3;

  // Configuration registers.
  logic [LW-1:0]                 low_limit_r, high_limit_r, clear_level_r;
  logic [bla_pkg::PERIOD_W-1:0]  check_per_r;

  // Input register.
  logic                        in_v_r;
  logic [bla_pkg::CMD_W-1:0]   cmd_r;
  logic [ADC_BITS-1:0]         adc_r;
  logic                        self_r;
  logic                        acc_r;

  // Monitor state.
  logic [TIMER_BITS-1:0] since_r, since_nxt;
  logic                  query_r, query_nxt;
  logic                  self_on_r, self_on_nxt;
  logic                  trig_r, trig_nxt;
  logic                  raised_r, raised_nxt;
  logic [LW-1:0]         last_level_r, last_level_nxt;

  // Result queue.
  bla_pkg::res_t   q_r [QD];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;

  logic            adv, pop;
  logic [1:0]      npush;
  bla_pkg::res_t   res0, res1;

  // Datapath signals.
  logic [PROD_W-1:0]     prod, diff;
  logic [SH_W+LW-1:0]    sh_ext;
  logic [LW-1:0]         lvl;
  logic [TIMER_BITS-1:0] since_inc;
  logic                  is_tick, periodic, meas, insuff, clr, raised1, trig2, ev;

  assign cfg_ch.ready = 1'b1;
  assign adv          = in_v_r && (cnt_r <= QC_W'(2));
  assign in_ch.ready  = !in_v_r || adv;
  assign pop          = out_ch.valid && out_ch.ready;

  // Converter sample to level: Q16 gain and offset, floored, clamped to 0..255.
  always_comb begin
    prod   = PROD_W'(adc_r) * PROD_W'(bla_pkg::GAIN_Q16);
    diff   = prod - PROD_W'(bla_pkg::OFFSET_Q16);
    sh_ext = {{LW{1'b0}}, diff[PROD_W-1:bla_pkg::FRAC_BITS]};
    if (prod < PROD_W'(bla_pkg::OFFSET_Q16)) begin
      lvl = '0;
    end else if (sh_ext > (SH_W+LW)'(255)) begin
      lvl = '1;
    end else begin
      lvl = sh_ext[LW-1:0];
    end
  end

  always_comb begin
    is_tick   = (cmd_r == bla_pkg::CMD_TICK);
    since_inc = (since_r == '1) ? since_r : since_r + TIMER_BITS'(1);
    // A pending query measures and clears the counter first, so the periodic
    // check can only fire on a tick without a query.
    periodic  = !query_r && !self_on_r &&
                (CMP_W'(since_inc) > CMP_W'(check_per_r));
    meas      = query_r || periodic;
    insuff    = !self_on_r && ((lvl <= low_limit_r) || (lvl > high_limit_r));
    clr       = meas && !self_on_r && !insuff && (lvl > clear_level_r) && raised_r;
    raised1   = raised_r && !clr;
    trig2     = (trig_r && !clr) || (periodic && insuff && !raised1);
    ev        = trig2 && !raised1;

    since_nxt      = since_r;
    query_nxt      = query_r;
    self_on_nxt    = self_on_r;
    trig_nxt       = trig_r;
    raised_nxt     = raised_r;
    last_level_nxt = last_level_r;
    npush          = 2'd0;
    res0           = '0;
    res1           = '0;

    if (adv) begin
      case (cmd_r)
        bla_pkg::CMD_TICK: begin
          since_nxt      = meas ? '0 : since_inc;
          last_level_nxt = meas ? lvl : last_level_r;
          query_nxt      = 1'b0;
          raised_nxt     = raised1 || (ev && acc_r);
          trig_nxt       = trig2 && !(ev && acc_r);
        end
        bla_pkg::CMD_QUERY: begin
          query_nxt = 1'b1;
        end
        bla_pkg::CMD_INFORM: begin
          self_on_nxt = self_r;
        end
        default: begin
        end
      endcase
    end

    // Results of a tick: the query reply first, then the event.
    if (query_r) begin
      res0.kind  = (insuff && !raised1) ? bla_pkg::KIND_LOW : bla_pkg::KIND_OK;
      res0.level = last_level_nxt;
      res0.last  = !ev;
      res1.kind  = bla_pkg::KIND_EVENT;
      res1.level = last_level_nxt;
      res1.last  = 1'b1;
    end else begin
      res0.kind  = bla_pkg::KIND_EVENT;
      res0.level = last_level_nxt;
      res0.last  = 1'b1;
    end
    if (adv && is_tick) begin
      npush = 2'(query_r) + 2'(ev);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r   <= bla_pkg::LOW_LIMIT_RST;
      high_limit_r  <= bla_pkg::HIGH_LIMIT_RST;
      clear_level_r <= bla_pkg::CLEAR_LEVEL_RST;
      check_per_r   <= bla_pkg::CHECK_PER_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        bla_pkg::REG_LOW_LIMIT:   low_limit_r   <= cfg_ch.data[LW-1:0];
        bla_pkg::REG_HIGH_LIMIT:  high_limit_r  <= cfg_ch.data[LW-1:0];
        bla_pkg::REG_CLEAR_LEVEL: clear_level_r <= cfg_ch.data[LW-1:0];
        bla_pkg::REG_CHECK_PER:   check_per_r   <= cfg_ch.data[bla_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      since_r      <= '0;
      query_r      <= 1'b0;
      self_on_r    <= 1'b0;
      trig_r       <= 1'b0;
      raised_r     <= 1'b0;
      last_level_r <= '0;
      wp_r         <= '0;
      rp_r         <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      since_r      <= since_nxt;
      query_r      <= query_nxt;
      self_on_r    <= self_on_nxt;
      trig_r       <= trig_nxt;
      raised_r     <= raised_nxt;
      last_level_r <= last_level_nxt;
      wp_r         <= wp_r + QA_W'(npush);
      rp_r         <= rp_r + QA_W'(pop);
      cnt_r        <= cnt_r + QC_W'(npush) - QC_W'(pop);
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= in_ch.command;
      adc_r  <= in_ch.adc_sample;
      self_r <= in_ch.self_started;
      acc_r  <= in_ch.event_accepted;
    end
    if (npush != 2'd0) begin
      q_r[wp_r] <= res0;
    end
    if (npush == 2'd2) begin
      q_r[wp_r + QA_W'(1)] <= res1;
    end
  end

  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.kind  = q_r[rp_r].kind;
  assign out_ch.level = q_r[rp_r].level;
  assign out_ch.last  = q_r[rp_r].last;

endmodule

[tb/battery_level_alarm_monitor_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the battery level alarm monitor: directed and
// random beats with a beat-level predictor and a scoreboard of results.
// Depends on bla_pkg, the channel interfaces in bla_if and the top level.
module battery_level_alarm_monitor_tb;

  localparam logic [bla_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam logic [bla_pkg::PERIOD_W-1:0] TIMER_MAX = {bla_pkg::PERIOD_W{1'b1}};
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_CYCLES  = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 100;

  // Tracks the monitor's state and holds the results still to come.
  class alarm_tracker;
    logic [bla_pkg::LEVEL_W-1:0]  low_limit, high_limit, clear_level, last_level;
    logic [bla_pkg::PERIOD_W-1:0] check_period, since_check;
    bit query_pending, self_on, alarm_trigger, alarm_raised;
    bla_pkg::res_t awaited_results[$];
    int errors;

    function new();
      low_limit = bla_pkg::LOW_LIMIT_RST;
      high_limit = bla_pkg::HIGH_LIMIT_RST;
      clear_level = bla_pkg::CLEAR_LEVEL_RST;
      check_period = bla_pkg::CHECK_PER_RST;
      since_check = '0;
      last_level = '0;
      query_pending = 0;
      self_on = 0;
      alarm_trigger = 0;
      alarm_raised = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [bla_pkg::CFG_IDX_W-1:0] idx,
                            logic [bla_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bla_pkg::REG_LOW_LIMIT:   low_limit = data[bla_pkg::LEVEL_W-1:0];
        bla_pkg::REG_HIGH_LIMIT:  high_limit = data[bla_pkg::LEVEL_W-1:0];
        bla_pkg::REG_CLEAR_LEVEL: clear_level = data[bla_pkg::LEVEL_W-1:0];
        bla_pkg::REG_CHECK_PER:   check_period = data[bla_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [9:0] adc);
      int prod;
      int lv;
      prod = int'(adc) * bla_pkg::GAIN_Q16;
      if (prod < bla_pkg::OFFSET_Q16) begin
        lv = 0;
      end else begin
        lv = (prod - bla_pkg::OFFSET_Q16) >> bla_pkg::FRAC_BITS;
        if (lv > 255) lv = 255;
      end
      last_level = lv[bla_pkg::LEVEL_W-1:0];
      since_check = '0;
    endfunction

    // With the mode on every level passes; otherwise a good level above the
    // clear level also drops a raised alarm.
    function bit level_ok();
      if (!self_on) begin
        if (last_level <= low_limit || last_level > high_limit) return 0;
        if (last_level > clear_level && alarm_raised) begin
          alarm_raised = 0;
          alarm_trigger = 0;
        end
      end
      return 1;
    endfunction

    function void note_beat(logic [bla_pkg::CMD_W-1:0] cmd, logic [9:0] adc, logic ss,
                            logic ea);
      bla_pkg::res_t r[2];
      int n;
      bit ok;
      n = 0;
      case (cmd)
        bla_pkg::CMD_QUERY:  query_pending = 1;
        bla_pkg::CMD_INFORM: self_on = ss;
        bla_pkg::CMD_TICK: begin
          if (since_check < TIMER_MAX) since_check++;
          if (query_pending) begin
            query_pending = 0;
            take_sample(adc);
            ok = level_ok();
            r[n].kind = (!ok && !alarm_raised) ? bla_pkg::KIND_LOW : bla_pkg::KIND_OK;
            r[n].level = last_level;
            r[n].last = 1'b0;
            n++;
          end
          if (since_check > check_period && !self_on) begin
            take_sample(adc);
            if (!level_ok() && !alarm_raised) alarm_trigger = 1;
          end
          if (alarm_trigger && !alarm_raised) begin
            r[n].kind = bla_pkg::KIND_EVENT;
            r[n].level = last_level;
            r[n].last = 1'b0;
            n++;
            if (ea) begin
              alarm_raised = 1;
              alarm_trigger = 0;
            end
          end
          if (n > 0) r[n-1].last = 1'b1;
          for (int i = 0; i < n; i++) awaited_results.push_back(r[i]);
        end
        default: ;
      endcase
    endfunction

    function void check_result(bla_pkg::res_t got);
      bla_pkg::res_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d, level %0d, last %0d",
               got.kind, got.level, got.last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.level !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, got.level);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int tx_idle_pct;
  int rx_idle_pct;
  bit stall_go;
  bit stall_active;
  int cycle_count;
  alarm_tracker tracker;

  bla_in_if #(.ADC_BITS(10)) in_ch();
  bla_out_if out_ch();
  bla_cfg_if cfg_ch();

  battery_level_alarm_monitor #(
    .ADC_BITS(10),
    .TIMER_BITS(18)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("battery_level_alarm_monitor_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !stall_active && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    stall_active = 1'b0;
    wait (stall_go);
    @(negedge clk);
    stall_active = 1'b1;
    repeat (STALL_CYCLES) @(negedge clk);
    stall_active = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result('{kind: out_ch.kind, level: out_ch.level, last: out_ch.last});
  end

  task automatic send_item(input logic [bla_pkg::CMD_W-1:0] cmd, input logic [9:0] adc,
                           input logic ss, input logic ea);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.adc_sample = adc;
    in_ch.self_started = ss;
    in_ch.event_accepted = ea;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_beat(cmd, adc, ss, ea);
    @(negedge clk);
  endtask

  // Wait for every result, then give the block time to finish silent beats.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bla_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input int low, input int high, input int clr, input int period);
    write_reg(bla_pkg::REG_LOW_LIMIT, bla_pkg::CFG_DATA_W'(low));
    write_reg(bla_pkg::REG_HIGH_LIMIT, bla_pkg::CFG_DATA_W'(high));
    write_reg(bla_pkg::REG_CLEAR_LEVEL, bla_pkg::CFG_DATA_W'(clr));
    write_reg(bla_pkg::REG_CHECK_PER, bla_pkg::CFG_DATA_W'(period));
    cfg_ch.valid = 1'b0;
  endtask

  // Mostly ticks with samples near the useful range; queries and mode
  // changes mixed in, and now and then the reserved command as noise.
  task automatic random_beat(output bit counted);
    int pick;
    logic [bla_pkg::CMD_W-1:0] cmd;
    logic [9:0] adc;
    logic ss;
    pick = $urandom_range(99);
    if (pick < 68) cmd = bla_pkg::CMD_TICK;
    else if (pick < 86) cmd = bla_pkg::CMD_QUERY;
    else if (pick < 97) cmd = bla_pkg::CMD_INFORM;
    else cmd = CMD_RESERVED;
    if ($urandom_range(99) < 70) adc = 10'($urandom_range(560, 1023));
    else adc = 10'($urandom_range(0, 1023));
    ss = (cmd == bla_pkg::CMD_INFORM) ? ($urandom_range(99) < 30) : 1'($urandom_range(1));
    send_item(cmd, adc, ss, 1'($urandom_range(1)));
    counted = (cmd != CMD_RESERVED);
  endtask

  initial begin
    bit counted;
    int done;
    tracker = new();
    rst_n = 1'b0;
    stall_go = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.command = bla_pkg::CMD_TICK;
    in_ch.adc_sample = '0;
    in_ch.self_started = 1'b0;
    in_ch.event_accepted = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bla_pkg::REG_LOW_LIMIT;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Queries under the reset settings: low, high, good, and with the mode on.
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd1023, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd600, 1'b0, 1'b1);
    send_item(bla_pkg::CMD_INFORM, 10'd0, 1'b1, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_INFORM, 10'd1023, 1'b0, 1'b1);
    send_item(CMD_RESERVED, 10'd1023, 1'b1, 1'b1);
    drain();

    // Check on every tick: the event repeats until taken, shares a tick with
    // a reply, then a good level clears the raised alarm.
    configure(2, 80, 3, 0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b1);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd800, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_INFORM, 10'd0, 1'b1, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_QUERY, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0);
    send_item(bla_pkg::CMD_INFORM, 10'd0, 1'b0, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(0, 255, 0, 0);
        2: configure(255, 0, 255, 262143);
        default: configure($urandom_range(0, 30), $urandom_range(20, 89),
                           $urandom_range(0, 60), $urandom_range(0, 25));
      endcase
      if (phase < 2) begin
        tx_idle_pct = 19;
        rx_idle_pct = 51;
      end else if (phase < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == 4) stall_go = 1'b1;
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_beat(counted);
        if (counted) done++;
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("battery_level_alarm_monitor_tb: PASS");
    end else begin
      $display("battery_level_alarm_monitor_tb: FAIL");
    end
    $finish;
  end

endmodule
